[rtl/vtrc_pkg.sv]
package vtrc_pkg;

   // sample and range register width
   localparam int SAMPLE_BITS = 24;

   // quotient of the normalization, 0 .. 65536 in unsigned q0.16 plus one bit
   localparam int Q_BITS = 17;
   localparam int FRAC_BITS = Q_BITS - 1;
   localparam int NUM_W = SAMPLE_BITS + Q_BITS;

   localparam logic [Q_BITS-1:0] ONE_Q16 = Q_BITS'(65536);

   // hue with 8 fraction bits
   localparam int HUE_W = 17;
   localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(71680);
   localparam int HUE_SPAN_DEG = 280;
   localparam int HUE_ROUND = 128;
   localparam int HUE_FRAC = 8;

   // one sextant of 60 degrees
   localparam int REM_W = 14;
   localparam int HUE_SEXTANT = 15360;
   localparam int CHAN_MAX = 255;

   // ramp: (part * 255 + 7680) / 15360 = ((...) >> 10) / 15
   localparam int RAMP_SHIFT = 10;
   localparam int RAMP_W = 12;
   localparam int DIV15_MUL = 4370;
   localparam int DIV15_SHIFT = 16;

   // pipeline stage positions
   localparam int S_CLAMP = 0;
   localparam int S_DIFF = 1;
   localparam int S_DIV0 = 2;
   localparam int S_HUE = S_DIV0 + Q_BITS;
   localparam int S_SEXT = S_HUE + 1;
   localparam int S_RAMP = S_SEXT + 1;
   localparam int S_OUT = S_RAMP + 1;
   localparam int N_STAGES = S_OUT + 1;

   typedef enum logic [0:0] {
      CSR_RANGE_MIN = 1'b0,
      CSR_RANGE_MAX = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      SEXT_RED_YEL = 3'd0,
      SEXT_YEL_GRN = 3'd1,
      SEXT_GRN_CYN = 3'd2,
      SEXT_CYN_BLU = 3'd3,
      SEXT_BLU_MAG = 3'd4,
      SEXT_MAG_RED = 3'd5
   } sextant_type;

endpackage

[rtl/value_to_rainbow_color_unit.sv]
// a req beat passes the clamp, diff, divider, hue, sextant, ramp and output stages
// throughput: one beat per cycle; each stage holds only while the stage after it is full
// and rsp_stall holds the output stage, so empty stages still take new beats
// reset (synchronous, active high) empties every stage and sets range_min 0, range_max 70
// normalization is a restoring divider, one quotient bit per stage
module value_to_rainbow_color_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  vtrc_pkg::csr_index_type              csr_index,
   input  logic [vtrc_pkg::SAMPLE_BITS-1:0]     csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [vtrc_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_red,
   output logic [7:0]                           rsp_green,
   output logic [7:0]                           rsp_blue,
   output logic                                 rsp_clamped
);
   import vtrc_pkg::*;

   localparam int W = SAMPLE_BITS;

   // configuration registers
   logic signed [W-1:0] range_min_ff;
   logic signed [W-1:0] range_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= W'(0);
         range_max_ff <= W'(70);
      end else if (csr_write) begin
         case (csr_index)
            CSR_RANGE_MIN: range_min_ff <= csr_data;
            CSR_RANGE_MAX: range_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stage valids and load enables
   // a stage loads when it is empty or the stage after it loads
   // ------------------------------------------------------------------
   logic [N_STAGES-1:0] valid_ff;
   logic [N_STAGES-1:0] load;
   logic [N_STAGES-1:0] clamped_ff;

   always_comb begin
      load[S_OUT] = !valid_ff[S_OUT] || !rsp_stall;
      for (int k = S_OUT - 1; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign req_stall = !load[S_CLAMP];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[S_CLAMP]) begin
            valid_ff[S_CLAMP] <= req_valid;
         end
         for (int k = 1; k < N_STAGES; k++) begin
            if (load[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // clamp flag rides along with every stage
   logic clamped_in;

   always_ff @(posedge clock) begin
      if (load[S_CLAMP]) begin
         clamped_ff[S_CLAMP] <= clamped_in;
      end
      for (int k = 1; k < N_STAGES; k++) begin
         if (load[k]) begin
            clamped_ff[k] <= clamped_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 0: clamp sample into [lower, upper] of the range
   // swapped bounds still clamp to the span between them
   // ------------------------------------------------------------------
   logic signed [W-1:0] lower;
   logic signed [W-1:0] upper;
   logic signed [W-1:0] sample_in;
   logic signed [W-1:0] sample_ff;

   always_comb begin
      lower = (range_min_ff < range_max_ff) ? range_min_ff : range_max_ff;
      upper = (range_min_ff < range_max_ff) ? range_max_ff : range_min_ff;
      sample_in = req_sample;
      clamped_in = 1'b0;
      if (req_sample < lower) begin
         sample_in = lower;
         clamped_in = 1'b1;
      end else if (req_sample > upper) begin
         sample_in = upper;
         clamped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load[S_CLAMP]) begin
         sample_ff <= sample_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: magnitudes of distance and span, rounded dividend
   // ------------------------------------------------------------------
   logic signed [W:0]   num_diff;
   logic signed [W:0]   den_diff;
   logic [W:0]          num_mag;
   logic [W:0]          den_mag;
   logic [NUM_W-1:0]    dividend_in;
   logic [NUM_W-1:0]    dividend_ff;
   logic [W-1:0]        divisor_ff;

   always_comb begin
      num_diff = {sample_ff[W-1], sample_ff} - {range_min_ff[W-1], range_min_ff};
      den_diff = {range_max_ff[W-1], range_max_ff} - {range_min_ff[W-1], range_min_ff};
      num_mag = num_diff[W] ? (W+1)'(-num_diff) : num_diff;
      den_mag = den_diff[W] ? (W+1)'(-den_diff) : den_diff;
      // distance times 2^16 plus half the span
      dividend_in = {1'b0, num_mag[W-1:0], FRAC_BITS'(0)}
                  + NUM_W'(den_mag[W-1:1]);
   end

   always_ff @(posedge clock) begin
      if (load[S_DIFF]) begin
         dividend_ff <= dividend_in;
         divisor_ff  <= den_mag[W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // stages 2 .. 18: restoring divider, one quotient bit per stage
   // the partial remainder starts as the dividend's upper bits, which
   // stay below the divisor because the distance never exceeds the span
   // ------------------------------------------------------------------
   logic [W-1:0]      div_rem_ff [Q_BITS];
   logic [Q_BITS-1:0] div_low_ff [Q_BITS];
   logic [Q_BITS-1:0] div_quo_ff [Q_BITS];
   logic [W-1:0]      div_den_ff [Q_BITS];

   logic [W-1:0]      div_rem_in [Q_BITS];
   logic [Q_BITS-1:0] div_low_in [Q_BITS];
   logic [Q_BITS-1:0] div_quo_in [Q_BITS];
   logic [W-1:0]      div_den_in [Q_BITS];

   always_comb begin
      logic [W-1:0]      rem_prev;
      logic [Q_BITS-1:0] low_prev;
      logic [Q_BITS-1:0] quo_prev;
      logic [W-1:0]      den_prev;
      logic [W:0]        trial;
      for (int j = 0; j < Q_BITS; j++) begin
         if (j == 0) begin
            rem_prev = dividend_ff[NUM_W-1:Q_BITS];
            low_prev = dividend_ff[Q_BITS-1:0];
            quo_prev = '0;
            den_prev = divisor_ff;
         end else begin
            rem_prev = div_rem_ff[j-1];
            low_prev = div_low_ff[j-1];
            quo_prev = div_quo_ff[j-1];
            den_prev = div_den_ff[j-1];
         end
         trial = {rem_prev, low_prev[Q_BITS-1]};
         div_low_in[j] = {low_prev[Q_BITS-2:0], 1'b0};
         div_den_in[j] = den_prev;
         if (trial >= {1'b0, den_prev}) begin
            div_rem_in[j] = W'(trial - {1'b0, den_prev});
            div_quo_in[j] = {quo_prev[Q_BITS-2:0], 1'b1};
         end else begin
            div_rem_in[j] = trial[W-1:0];
            div_quo_in[j] = {quo_prev[Q_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < Q_BITS; j++) begin
         if (load[S_DIV0+j]) begin
            div_rem_ff[j] <= div_rem_in[j];
            div_low_ff[j] <= div_low_in[j];
            div_quo_ff[j] <= div_quo_in[j];
            div_den_ff[j] <= div_den_in[j];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 19: hue = ((1 - value) * 280 + 128) >> 8
   // equal bounds give a zero divisor and an all-ones quotient, which
   // saturates to 1.0 here, so that case comes out pure red
   // ------------------------------------------------------------------
   logic [Q_BITS-1:0] value;
   logic [Q_BITS-1:0] inv_value;
   logic [Q_BITS+9:0] hue_prod;
   logic [HUE_W-1:0]  hue_in;
   logic [HUE_W-1:0]  hue_ff;

   always_comb begin
      value = (div_quo_ff[Q_BITS-1] > ONE_Q16) ? ONE_Q16 : div_quo_ff[Q_BITS-1];
      inv_value = ONE_Q16 - value;
      hue_prod = (Q_BITS+10)'(inv_value) * (Q_BITS+10)'(HUE_SPAN_DEG)
               + (Q_BITS+10)'(HUE_ROUND);
      hue_in = HUE_W'(hue_prod >> HUE_FRAC);
   end

   always_ff @(posedge clock) begin
      if (load[S_HUE]) begin
         hue_ff <= hue_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 20: sextant by threshold compares, remainder within it
   // ------------------------------------------------------------------
   logic [2:0]       sext_in;
   logic [REM_W-1:0] rem_in;
   logic [HUE_W-1:0] base;
   sextant_type      sext_ff;
   logic [REM_W-1:0] rem_ff;

   always_comb begin
      sext_in = 3'd0;
      for (int t = 1; t < 6; t++) begin
         if (hue_ff >= HUE_W'(t * HUE_SEXTANT)) begin
            sext_in = 3'(t);
         end
      end
      base = HUE_W'(sext_in) * HUE_W'(HUE_SEXTANT);
      rem_in = REM_W'(hue_ff - base);
   end

   always_ff @(posedge clock) begin
      if (load[S_SEXT]) begin
         sext_ff <= sextant_type'(sext_in);
         rem_ff  <= rem_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 21: ramp numerators, scaled by 255 and pre-divided by 1024
   // ------------------------------------------------------------------
   logic [21:0]       up_num;
   logic [21:0]       down_num;
   logic [RAMP_W-1:0] up_part_ff;
   logic [RAMP_W-1:0] down_part_ff;
   sextant_type       sext2_ff;

   always_comb begin
      up_num = 22'(rem_ff) * 22'(CHAN_MAX) + 22'(HUE_SEXTANT / 2);
      down_num = (22'(HUE_SEXTANT) - 22'(rem_ff)) * 22'(CHAN_MAX)
               + 22'(HUE_SEXTANT / 2);
   end

   always_ff @(posedge clock) begin
      if (load[S_RAMP]) begin
         up_part_ff   <= RAMP_W'(up_num >> RAMP_SHIFT);
         down_part_ff <= RAMP_W'(down_num >> RAMP_SHIFT);
         sext2_ff     <= sext_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 22: divide by 15 via reciprocal, six-way channel select
   // ------------------------------------------------------------------
   logic [RAMP_W+12:0] up_prod;
   logic [RAMP_W+12:0] down_prod;
   logic [7:0]         up;
   logic [7:0]         down;
   logic [7:0]         red_in;
   logic [7:0]         green_in;
   logic [7:0]         blue_in;
   logic [7:0]         red_ff;
   logic [7:0]         green_ff;
   logic [7:0]         blue_ff;

   always_comb begin
      up_prod = (RAMP_W+13)'(up_part_ff) * (RAMP_W+13)'(DIV15_MUL);
      down_prod = (RAMP_W+13)'(down_part_ff) * (RAMP_W+13)'(DIV15_MUL);
      up = 8'(up_prod >> DIV15_SHIFT);
      down = 8'(down_prod >> DIV15_SHIFT);
      case (sext2_ff)
         SEXT_RED_YEL: begin
            red_in = 8'(CHAN_MAX); green_in = up; blue_in = 8'd0;
         end
         SEXT_YEL_GRN: begin
            red_in = down; green_in = 8'(CHAN_MAX); blue_in = 8'd0;
         end
         SEXT_GRN_CYN: begin
            red_in = 8'd0; green_in = 8'(CHAN_MAX); blue_in = up;
         end
         SEXT_CYN_BLU: begin
            red_in = 8'd0; green_in = down; blue_in = 8'(CHAN_MAX);
         end
         SEXT_BLU_MAG: begin
            red_in = up; green_in = 8'd0; blue_in = 8'(CHAN_MAX);
         end
         default: begin
            red_in = 8'(CHAN_MAX); green_in = 8'd0; blue_in = down;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[S_OUT]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid   = valid_ff[S_OUT];
   assign rsp_red     = red_ff;
   assign rsp_green   = green_ff;
   assign rsp_blue    = blue_ff;
   assign rsp_clamped = clamped_ff[S_OUT];

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------

   // input backs up only when every stage is full and the output is held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && (&valid_ff)))
      else $error("input stalled with room in the pipeline");

   // hue never passes 280 degrees, whatever the divider produced
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_HUE] |-> (hue_ff <= HUE_MAX))
      else $error("hue out of range");

   // a fully saturated color has one channel at full scale and one at zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_red == 8'd255 || rsp_green == 8'd255 || rsp_blue == 8'd255)
                  && (rsp_red == 8'd0 || rsp_green == 8'd0 || rsp_blue == 8'd0)))
      else $error("color not fully saturated");

   // a held result stays in place
   assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && rsp_stall) |-> (rsp_valid && $stable(red_ff)
                                         && $stable(blue_ff) && $stable(green_ff)))
      else $error("stalled result changed");

endmodule

[tb/value_to_rainbow_color_unit_tb.sv]
module value_to_rainbow_color_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vtrc_pkg::*;

   // pipeline depth of the block; the tail wait below runs twice as long
   localparam int PIPE_LATENCY = 23;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint UNIT_Q16 = 65536;

   // expected color of one rsp beat
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       clamped;
   } color_type;

   // one line of the directed plan: either a range write or a sample beat
   typedef struct packed {
      logic                   is_write;
      csr_index_type          index;
      logic [SAMPLE_BITS-1:0] value;
      logic                   typed;
      color_type              want;
   } plan_row_type;

   localparam color_type NO_COLOR       = '0;
   localparam color_type RED            = '{8'd255, 8'd0, 8'd0, 1'b0};
   localparam color_type RED_CLAMPED    = '{8'd255, 8'd0, 8'd0, 1'b1};
   localparam color_type VIOLET         = '{8'd170, 8'd0, 8'd255, 1'b0};
   localparam color_type VIOLET_CLAMPED = '{8'd170, 8'd0, 8'd255, 1'b1};

   localparam logic [SAMPLE_BITS-1:0] MOST_NEG = 24'h800000;
   localparam logic [SAMPLE_BITS-1:0] MOST_POS = 24'h7FFFFF;

   // directed plan: typed colors only where they are obvious (range ends, clamps)
   localparam plan_row_type DIRECTED_PLAN [26] = '{
      // reset range 0 .. 70
      '{1'b0, CSR_RANGE_MIN, 24'd70,     1'b1, RED},
      '{1'b0, CSR_RANGE_MIN, 24'd0,      1'b1, VIOLET},
      '{1'b0, CSR_RANGE_MIN, 24'd35,     1'b0, NO_COLOR},
      '{1'b0, CSR_RANGE_MIN, 24'hFFFFFF, 1'b1, VIOLET_CLAMPED},
      '{1'b0, CSR_RANGE_MIN, 24'd71,     1'b1, RED_CLAMPED},
      '{1'b0, CSR_RANGE_MIN, MOST_NEG,   1'b1, VIOLET_CLAMPED},
      '{1'b0, CSR_RANGE_MIN, MOST_POS,   1'b1, RED_CLAMPED},
      // walk through every sextant the hue reaches
      '{1'b0, CSR_RANGE_MIN, 24'd10,     1'b0, NO_COLOR},
      '{1'b0, CSR_RANGE_MIN, 24'd20,     1'b0, NO_COLOR},
      '{1'b0, CSR_RANGE_MIN, 24'd30,     1'b0, NO_COLOR},
      '{1'b0, CSR_RANGE_MIN, 24'd50,     1'b0, NO_COLOR},
      '{1'b0, CSR_RANGE_MIN, 24'd60,     1'b0, NO_COLOR},
      '{1'b0, CSR_RANGE_MIN, 24'd67,     1'b0, NO_COLOR},
      // widest span the registers can hold
      '{1'b1, CSR_RANGE_MIN, MOST_NEG,   1'b0, NO_COLOR},
      '{1'b1, CSR_RANGE_MAX, MOST_POS,   1'b0, NO_COLOR},
      '{1'b0, CSR_RANGE_MIN, MOST_NEG,   1'b1, VIOLET},
      '{1'b0, CSR_RANGE_MIN, MOST_POS,   1'b1, RED},
      '{1'b0, CSR_RANGE_MIN, 24'd0,      1'b0, NO_COLOR},
      // equal bounds give red, clamped only off the single point
      '{1'b1, CSR_RANGE_MIN, 24'd100,    1'b0, NO_COLOR},
      '{1'b1, CSR_RANGE_MAX, 24'd100,    1'b0, NO_COLOR},
      '{1'b0, CSR_RANGE_MIN, 24'd100,    1'b1, RED},
      '{1'b0, CSR_RANGE_MIN, 24'd5,      1'b1, RED_CLAMPED},
      // swapped bounds at the extremes
      '{1'b1, CSR_RANGE_MIN, MOST_POS,   1'b0, NO_COLOR},
      '{1'b1, CSR_RANGE_MAX, MOST_NEG,   1'b0, NO_COLOR},
      '{1'b0, CSR_RANGE_MIN, MOST_POS,   1'b1, VIOLET},
      '{1'b0, CSR_RANGE_MIN, MOST_NEG,   1'b1, RED}
   };

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          csr_write = 1'b0;
   csr_index_type                 csr_index = CSR_RANGE_MIN;
   logic [SAMPLE_BITS-1:0]        csr_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [7:0]                    rsp_red;
   logic [7:0]                    rsp_green;
   logic [7:0]                    rsp_blue;
   logic                          rsp_clamped;

   // own copy of the range registers, reset values of the block
   logic signed [SAMPLE_BITS-1:0] range_min_q = 24'sd0;
   logic signed [SAMPLE_BITS-1:0] range_max_q = 24'sd70;

   color_type pending_colors [$];
   int        mismatches = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 0;
   int        stall_pct = 0;

   value_to_rainbow_color_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .rsp_clamped (rsp_clamped)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // color of one sample under the current range: clamp, normalize, hue, hsv ramps
   function automatic color_type rainbow_color_of(logic signed [SAMPLE_BITS-1:0] sample);
      longint    s, mn, mx, lo, hi, num, den, value, hue, rem, up, down;
      color_type c;
      s  = sample;
      mn = range_min_q;
      mx = range_max_q;
      lo = (mn < mx) ? mn : mx;
      hi = (mn < mx) ? mx : mn;
      c.clamped = 1'b0;
      if (s < lo) begin
         s = lo;
         c.clamped = 1'b1;
      end
      if (s > hi) begin
         s = hi;
         c.clamped = 1'b1;
      end
      if (mx == mn) begin
         value = UNIT_Q16;
      end else begin
         num   = (s >= mn) ? s - mn : mn - s;
         den   = (mx >= mn) ? mx - mn : mn - mx;
         value = (num * UNIT_Q16 + den / 2) / den;
         if (value > UNIT_Q16) value = UNIT_Q16;
      end
      // hue in degrees with 8 fraction bits, 280 deg at the violet end
      hue  = ((UNIT_Q16 - value) * HUE_SPAN_DEG + HUE_ROUND) / 256;
      rem  = hue % HUE_SEXTANT;
      up   = (rem * CHAN_MAX + HUE_SEXTANT / 2) / HUE_SEXTANT;
      down = ((HUE_SEXTANT - rem) * CHAN_MAX + HUE_SEXTANT / 2) / HUE_SEXTANT;
      case (sextant_type'(3'((hue / HUE_SEXTANT) % 6)))
         SEXT_RED_YEL: begin
            c.red = 8'd255;   c.green = 8'(up);   c.blue = 8'd0;
         end
         SEXT_YEL_GRN: begin
            c.red = 8'(down); c.green = 8'd255;   c.blue = 8'd0;
         end
         SEXT_GRN_CYN: begin
            c.red = 8'd0;     c.green = 8'd255;   c.blue = 8'(up);
         end
         SEXT_CYN_BLU: begin
            c.red = 8'd0;     c.green = 8'(down); c.blue = 8'd255;
         end
         SEXT_BLU_MAG: begin
            c.red = 8'(up);   c.green = 8'd0;     c.blue = 8'd255;
         end
         default: begin
            c.red = 8'd255;   c.green = 8'd0;     c.blue = 8'(down);
         end
      endcase
      return c;
   endfunction

   // hold req_valid low until every pending color has come back; waits on the clock first
   task automatic drain_pending();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_colors.size() != 0);
   endtask

   // range write, only with the pipeline empty
   task automatic write_range(csr_index_type index, logic [SAMPLE_BITS-1:0] data);
      drain_pending();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_RANGE_MIN) range_min_q = data;
      else range_max_q = data;
   endtask

   // one req beat with random idle cycles ahead of it; the color is queued once accepted
   task automatic send_sample(logic [SAMPLE_BITS-1:0] sample, color_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid  <= 1'b0;
         req_sample <= SAMPLE_BITS'($urandom());
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_colors = {pending_colors, want};
   endtask

   // new random range: wide random, narrow, swapped, equal or the extremes
   task automatic pick_ranges();
      logic [SAMPLE_BITS-1:0] a, b;
      int                     base;
      base = int'($urandom_range(2000)) - 1000;
      case ($urandom_range(5))
         0, 1: begin
            a = SAMPLE_BITS'($urandom());
            b = SAMPLE_BITS'($urandom());
         end
         2: begin
            a = SAMPLE_BITS'(base);
            b = SAMPLE_BITS'(base + int'($urandom_range(500, 1)));
         end
         3: begin
            b = SAMPLE_BITS'(base);
            a = SAMPLE_BITS'(base + int'($urandom_range(500, 1)));
         end
         4: begin
            a = SAMPLE_BITS'($urandom());
            b = a;
         end
         default: begin
            a = $urandom_range(1) ? MOST_NEG : MOST_POS;
            b = ~a;
         end
      endcase
      write_range(CSR_RANGE_MIN, a);
      write_range(CSR_RANGE_MAX, b);
   endtask

   // mostly samples inside the range, some at its ends, some beyond, some anywhere
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      longint lo, hi;
      lo = (range_min_q < range_max_q) ? range_min_q : range_max_q;
      hi = (range_min_q < range_max_q) ? range_max_q : range_min_q;
      case ($urandom_range(19))
         0:          return 24'(lo);
         1:          return 24'(hi);
         2, 3, 4, 5: return SAMPLE_BITS'($urandom());
         6:          return 24'(lo - longint'($urandom_range(64, 1)));
         7:          return 24'(hi + longint'($urandom_range(64, 1)));
         default:    return 24'(lo + longint'($urandom_range(32'(hi - lo))));
      endcase
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t rsp %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // receiver stall, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // result checker: every accepted rsp beat against the oldest pending color
   always @(posedge clock) begin
      color_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colors.size() == 0) begin
            mismatches++;
            $display("%0t rsp beat with nothing pending: expected none, actual %0d %0d %0d %0d",
                     $time, rsp_red, rsp_green, rsp_blue, rsp_clamped);
         end else begin
            want = pending_colors.pop_front();
            check_field("red", want.red, rsp_red);
            check_field("green", want.green, rsp_green);
            check_field("blue", want.blue, rsp_blue);
            check_field("clamped", 8'(want.clamped), 8'(rsp_clamped));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[value_to_rainbow_color_unit] ERROR");
         $finish;
      end
   end

   initial begin
      plan_row_type           row;
      logic [SAMPLE_BITS-1:0] sample;

      // reset once, then release it
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part under the first idle mix
      send_idle_pct = 29;
      stall_pct     = 85;
      foreach (DIRECTED_PLAN[i]) begin
         row = DIRECTED_PLAN[i];
         if (row.is_write) begin
            write_range(row.index, row.value);
         end else begin
            send_sample(row.value, row.typed ? row.want : rainbow_color_of(row.value));
         end
      end

      // random part: sender busy / receiver slow, then swapped, then full rate
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 85 : 0;
         stall_pct     = (phase == 0) ? 85 : (phase == 1) ? 29 : 0;
         for (int batch = 0; batch < 10; batch++) begin
            pick_ranges();
            for (int n = 0; n < 53; n++) begin
               // sender backs off until the pipeline runs dry
               if (batch == 5 && n == 20) drain_pending();
               sample = pick_sample();
               send_sample(sample, rainbow_color_of(sample));
            end
         end
      end

      // let the pipeline empty, then watch a while for stray beats
      drain_pending();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (pending_colors.size() != 0) mismatches++;

      if (mismatches == 0) begin
         $display("[value_to_rainbow_color_unit] OK");
      end else begin
         $display("[value_to_rainbow_color_unit] ERROR");
      end
      $finish;
   end

endmodule
